### hw/rtl/hsg_pkg.sv
// ----------------------------------------------------------------------------
// hsg_pkg
// Shared types and constants for the Halton sequence generator.
// ----------------------------------------------------------------------------
package hsg_pkg;

   // default sizing
   localparam int MAX_DIGITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 32;

   // fixed field widths
   localparam int BASE_W     = 8;
   localparam int SEED_W     = 32;
   localparam int SAMPLE_W   = 32;
   localparam int REQ_DATA_W = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // smallest usable radix; lower writes are taken as this
   localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE  = CSR_IDX_W'(0),
      CSR_START = CSR_IDX_W'(1)
   } csr_reg_type;

   // controller -> datapath commands
   typedef struct packed {
      logic wr_base;      // latch radix, clear index, start weight build
      logic wr_start;     // latch seed
      logic load_start;   // clear index, start seed decomposition
      logic div_step;     // one restoring-division step
      logic build_store;  // store weight and (b-1)*weight, next digit
      logic load_mul;     // store seed digit, form digit*weight
      logic load_acc;     // accumulate product, next digit
      logic emit;         // sample taken, ripple starts at digit 0
      logic ripple;       // one carry-ripple step
   } ctrl_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic div_last;     // final division step this cycle
      logic idx_last;     // digit pointer on the top digit
      logic quo_zero;     // quotient is zero, remaining digits are zero
      logic rip_fits;     // incremented digit stays below the radix
   } dp_status_type;

endpackage

### hw/rtl/halton_sequence_generator_unit.sv
// ----------------------------------------------------------------------------
// halton_sequence_generator_unit
// One-dimensional Halton (radical-inverse) sample generator, 0.32 output.
// ----------------------------------------------------------------------------
//
//  channel | ports          | payload                  | direction
//  --------+----------------+--------------------------+----------
//  request | req_t*         | tdata[0] restart         | in
//  result  | rsp_t*         | tdata[31:0] sample       | out
//  config  | csr_*          | index 0 base, 1 start    | in
//
//  Without restart, a taken request goes to emit, then the carry ripple visits k digits (1 for
//  most indices, at most MAX_DIGITS) before the next request. A restart first runs, per seed
//  digit, the bit-serial divider by the radix over DW = max(FRAC_BITS + 1, 32) dividend bits.
//  A base write rebuilds the weights digit by digit for MAX_DIGITS digits, no transfer taken.
//  Synchronous reset restores radix 2, seed 0, index 0 and the radix-2 weights.
//  A stalled result sits in the output register; the next request waits for that slot.
//
module halton_sequence_generator_unit #(
   parameter int MAX_DIGITS = hsg_pkg::MAX_DIGITS_DEF,
   parameter int FRAC_BITS  = hsg_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hsg_pkg::REQ_DATA_W-1:0] req_tdata,   // [0] restart, [7:1] zero
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hsg_pkg::SAMPLE_W-1:0]   rsp_tdata,   // [31:0] sample
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hsg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hsg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hsg_pkg::*;

   ctrl_cmd_type        cmd;
   dp_status_type       status;
   logic [SAMPLE_W-1:0] sample;
   logic                out_free;

   // output register: holds one finished sample until the sink takes it
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   // the slot is free if empty or draining on this edge
   assign out_free = !rsp_valid_ff || rsp_tready;

   hsg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_restart (req_tdata[0]),
      .out_free    (out_free),
      .status      (status),
      .cmd         (cmd)
   );

   hsg_datapath #(
      .MAX_DIGITS (MAX_DIGITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wdata (csr_wdata),
      .status    (status),
      .sample    (sample)
   );

   // emit only happens after a request was taken with the slot free, and
   // nothing else fills it in between
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/hsg_ctrl.sv
// ----------------------------------------------------------------------------
// hsg_ctrl
// Sequencer for weight build, seed load, sample emit and index carry ripple.
// ----------------------------------------------------------------------------
module hsg_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hsg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   input  logic                          out_free,
   input  hsg_pkg::dp_status_type        status,
   output hsg_pkg::ctrl_cmd_type         cmd
);
   import hsg_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_BDIV   = 8'b0000_0010,
      ST_BSTORE = 8'b0000_0100,
      ST_LDIV   = 8'b0000_1000,
      ST_LMUL   = 8'b0001_0000,
      ST_LACC   = 8'b0010_0000,
      ST_EMIT   = 8'b0100_0000,
      ST_RIPPLE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      csr_ready = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = out_free && !csr_valid;
            if (csr_valid) begin
               if (csr_index == CSR_BASE) begin
                  cmd.wr_base = 1'b1;
                  state_in    = ST_BDIV;
               end else if (csr_index == CSR_START) begin
                  cmd.wr_start = 1'b1;
               end
            end else if (req_valid && out_free) begin
               if (req_restart) begin
                  cmd.load_start = 1'b1;
                  state_in       = ST_LDIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_BDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_BSTORE;
            end
         end
         ST_BSTORE: begin
            cmd.build_store = 1'b1;
            state_in = status.idx_last ? ST_IDLE : ST_BDIV;
         end
         ST_LDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_LMUL;
            end
         end
         ST_LMUL: begin
            cmd.load_mul = 1'b1;
            state_in     = ST_LACC;
         end
         ST_LACC: begin
            cmd.load_acc = 1'b1;
            state_in = (status.idx_last || status.quo_zero) ? ST_EMIT : ST_LDIV;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_RIPPLE;
         end
         ST_RIPPLE: begin
            cmd.ripple = 1'b1;
            if (status.rip_fits || status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/hsg_datapath.sv
// ----------------------------------------------------------------------------
// hsg_datapath
// Digit counter, weight tables, running sum and a bit-serial divider by the
// radix, shared by weight build and seed decomposition.
// ----------------------------------------------------------------------------
module hsg_datapath #(
   parameter int MAX_DIGITS = hsg_pkg::MAX_DIGITS_DEF,
   parameter int FRAC_BITS  = hsg_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hsg_pkg::ctrl_cmd_type          cmd,
   input  logic [hsg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output hsg_pkg::dp_status_type         status,
   output logic [hsg_pkg::SAMPLE_W-1:0]   sample
);
   import hsg_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int DW    = (FRAC_BITS + 1 > SEED_W) ? FRAC_BITS + 1 : SEED_W;
   localparam int CNT_W = $clog2(DW);
   localparam int PW    = FRAC_BITS + BASE_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIGITS - 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);
   localparam logic [DW-1:0]    ONE_FRAC = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic [BASE_W-1:0]    base_ff, base_in;
   logic [SEED_W-1:0]    start_ff, start_in;
   logic [BASE_W-1:0]    digit_ff  [MAX_DIGITS];
   logic [BASE_W-1:0]    digit_in  [MAX_DIGITS];
   logic [FRAC_BITS-1:0] weight_ff [MAX_DIGITS];
   logic [FRAC_BITS-1:0] weight_in [MAX_DIGITS];
   logic [FRAC_BITS-1:0] mult_ff   [MAX_DIGITS];   // (b-1) * weight
   logic [FRAC_BITS-1:0] mult_in   [MAX_DIGITS];
   logic [FRAC_BITS-1:0] sum_ff, sum_in;
   logic [FRAC_BITS-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [BASE_W-1:0]    rem_ff, rem_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [BASE_W:0]      trial;
   logic [BASE_W:0]      trial_diff;
   logic                 trial_ge;
   logic [BASE_W-1:0]    base_m1;
   logic [PW-1:0]        build_prod;
   logic [PW-1:0]        load_prod;
   logic [BASE_W:0]      digit_inc;
   logic [FRAC_BITS+SAMPLE_W-1:0] sum_ext;

   // restoring division step: shift in the next dividend bit
   assign trial      = {rem_ff, quo_ff[DW-1]};
   assign trial_diff = trial - {1'b0, base_ff};
   assign trial_ge   = trial >= {1'b0, base_ff};

   assign base_m1    = base_ff - BASE_W'(1);
   assign build_prod = PW'(base_m1) * PW'(quo_ff[FRAC_BITS-1:0]);
   assign load_prod  = PW'(rem_ff) * PW'(weight_ff[idx_ff]);
   assign digit_inc  = {1'b0, digit_ff[idx_ff]} + (BASE_W+1)'(1);

   // top 32 bits of the 0.FRAC_BITS sum, zero-filled when FRAC_BITS < 32
   assign sum_ext = {sum_ff, {SAMPLE_W{1'b0}}};
   assign sample  = sum_ext[FRAC_BITS+SAMPLE_W-1 -: SAMPLE_W];

   assign status.div_last = cnt_ff == CNT_LAST;
   assign status.idx_last = idx_ff == IDX_LAST;
   assign status.quo_zero = quo_ff == '0;
   assign status.rip_fits = digit_inc < {1'b0, base_ff};

   always_comb begin
      base_in   = base_ff;
      start_in  = start_ff;
      digit_in  = digit_ff;
      weight_in = weight_ff;
      mult_in   = mult_ff;
      sum_in    = sum_ff;
      prod_in   = prod_ff;
      idx_in    = idx_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;

      if (cmd.wr_base) begin
         base_in = (csr_wdata[BASE_W-1:0] < BASE_MIN) ? BASE_MIN : csr_wdata[BASE_W-1:0];
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_in[i] = '0;
         end
         sum_in = '0;
         idx_in = '0;
         rem_in = '0;
         cnt_in = '0;
         quo_in = ONE_FRAC;
      end
      if (cmd.wr_start) begin
         start_in = csr_wdata[SEED_W-1:0];
      end
      if (cmd.load_start) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_in[i] = '0;
         end
         sum_in = '0;
         idx_in = '0;
         rem_in = '0;
         cnt_in = '0;
         quo_in = DW'(start_ff);
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[BASE_W-1:0] : trial[BASE_W-1:0];
         quo_in = {quo_ff[DW-2:0], trial_ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.build_store) begin
         weight_in[idx_ff] = quo_ff[FRAC_BITS-1:0];
         mult_in[idx_ff]   = build_prod[FRAC_BITS-1:0];
         idx_in = idx_ff + IDX_W'(1);
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.load_mul) begin
         digit_in[idx_ff] = rem_ff;
         prod_in = load_prod[FRAC_BITS-1:0];
      end
      if (cmd.load_acc) begin
         sum_in = sum_ff + prod_ff;
         idx_in = idx_ff + IDX_W'(1);
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.emit) begin
         idx_in = '0;
      end
      if (cmd.ripple) begin
         if (status.rip_fits) begin
            digit_in[idx_ff] = digit_inc[BASE_W-1:0];
            sum_in = sum_ff + weight_ff[idx_ff];
         end else begin
            // digit was b-1: drop its whole contribution and carry on
            digit_in[idx_ff] = '0;
            sum_in = sum_ff - mult_ff[idx_ff];
         end
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // architectural state; weights reset to the radix-2 table
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_MIN;
         start_ff <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_ff[i] <= '0;
            if (i < FRAC_BITS) begin
               weight_ff[i] <= {{(FRAC_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS - 1 - i);
               mult_ff[i]   <= {{(FRAC_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS - 1 - i);
            end else begin
               weight_ff[i] <= '0;
               mult_ff[i]   <= '0;
            end
         end
      end else begin
         base_ff   <= base_in;
         start_ff  <= start_in;
         sum_ff    <= sum_in;
         digit_ff  <= digit_in;
         weight_ff <= weight_in;
         mult_ff   <= mult_in;
      end
   end

   // working registers, always set up before use
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
